// ===== rtl/core/sapq_pkg.sv =====
// Shared types and codes for the sorted array priority queue.
// No dependencies.
package sapq_pkg;

  localparam int DATA_W = 32;
  localparam int ACT_W = 2;
  localparam int ST_W = 2;
  localparam int CNT_OUT_W = 5;
  localparam int DEF_CAPACITY = 16;

  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_PEEK = 2'd2;

  localparam logic [ST_W-1:0] ST_OK = 2'd0;
  localparam logic [ST_W-1:0] ST_OVERFLOW = 2'd1;
  localparam logic [ST_W-1:0] ST_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic vld;
    logic signed [DATA_W-1:0] val;
  } cell_t;

  typedef struct packed {
    logic ins;
    logic rem;
    logic signed [DATA_W-1:0] value;
  } ctl_t;

endpackage

// ===== rtl/core/sapq_cell.sv =====
// One queue cell: holds one entry and its valid bit, shifts with its neighbors.
// Depends on sapq_pkg.
module sapq_cell (
  input  logic           clk,
  input  logic           rst,
  input  sapq_pkg::ctl_t ctl,
  input  sapq_pkg::cell_t left,
  input  logic           left_ge,
  input  sapq_pkg::cell_t right,
  output sapq_pkg::cell_t q,
  output logic           ge,
  output sapq_pkg::cell_t nxt
);

  assign ge = !q.vld || (q.val >= ctl.value);

  always_comb begin
    nxt = q;
    priority if (ctl.rem) begin
      nxt = right;
    end else if (ctl.ins && ge) begin
      if (left_ge) begin
        nxt = left;
      end else begin
        nxt.vld = 1'b1;
        nxt.val = ctl.value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.vld <= 1'b0;
    end else begin
      q.vld <= nxt.vld;
    end
    q.val <= nxt.val;
  end

endmodule

// ===== rtl/core/sorted_array_priority_queue.sv =====
// Top level of the sorted min priority queue: a chain of compare-and-shift cells.
// Depends on sapq_pkg and sapq_cell.
//
//  channel | dir | tdata fields (low bit up)
//  s       | in  | action[1:0], value[33:2], zero pad [39:34]
//  m       | out | front_value[31:0], front_valid[32], status[34:33], entry_count[39:35]
//
// One word per cycle while no result waits unread: every cell compares against
// the new value and shifts in the same cycle, whatever the fill.
// The result is registered; a new word is taken while the result is taken
// the same cycle, and input stalls only while a result waits unread.
// Reset empties the queue; entry contents stay undefined until written.
module sorted_array_priority_queue #(
  parameter int CAPACITY = sapq_pkg::DEF_CAPACITY
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // action[1:0], value[33:2]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // front_value, front_valid, status, entry_count
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [sapq_pkg::ACT_W-1:0] action;
  logic signed [sapq_pkg::DATA_W-1:0] value;
  logic accept;
  logic full;
  logic empty;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [sapq_pkg::ST_W-1:0] status;
  sapq_pkg::ctl_t ctl;
  sapq_pkg::cell_t cells [CAPACITY];
  sapq_pkg::cell_t nxts [CAPACITY];
  logic [CAPACITY-1:0] ges;
  logic [CAPACITY-1:0] vlds;
  logic [39:0] result;

  assign action = s_tdata[1:0];
  assign value = s_tdata[33:2];
  assign s_tready = !m_tvalid || m_tready;
  assign accept = s_tvalid && s_tready;
  assign full = cells[CAPACITY-1].vld;
  assign empty = (count == '0);

  assign ctl.ins = accept && (action == sapq_pkg::ACT_INSERT) && !full;
  assign ctl.rem = accept && (action == sapq_pkg::ACT_REMOVE) && !empty;
  assign ctl.value = value;

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      sapq_pkg::cell_t left;
      sapq_pkg::cell_t right;
      logic left_ge;
      if (i == 0) begin : g_head
        assign left = '{vld: 1'b1, val: value};
        assign left_ge = 1'b0;
      end else begin : g_body
        assign left = cells[i-1];
        assign left_ge = ges[i-1];
      end
      if (i == CAPACITY - 1) begin : g_tail
        assign right = '{vld: 1'b0, val: '0};
      end else begin : g_mid
        assign right = cells[i+1];
      end
      sapq_cell u_cell (
        .clk     (clk),
        .rst     (rst),
        .ctl     (ctl),
        .left    (left),
        .left_ge (left_ge),
        .right   (right),
        .q       (cells[i]),
        .ge      (ges[i]),
        .nxt     (nxts[i])
      );
      assign vlds[i] = cells[i].vld;
    end
  endgenerate

  always_comb begin
    count_next = count;
    status = sapq_pkg::ST_OK;
    unique case (action)
      sapq_pkg::ACT_INSERT: begin
        if (full) begin
          status = sapq_pkg::ST_OVERFLOW;
        end else begin
          count_next = count + 1'b1;
        end
      end
      sapq_pkg::ACT_REMOVE: begin
        if (empty) begin
          status = sapq_pkg::ST_UNDERFLOW;
        end else begin
          count_next = count - 1'b1;
        end
      end
      default: begin
        if (empty) begin
          status = sapq_pkg::ST_UNDERFLOW;
        end
      end
    endcase
  end

  assign result = {sapq_pkg::CNT_OUT_W'(count_next), status, nxts[0].vld,
                   (nxts[0].vld ? nxts[0].val : {sapq_pkg::DATA_W{1'b0}})};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        count <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= result;
    end
  end

  a_count_matches_cells: assert property (@(posedge clk) disable iff (rst)
    int'(count) == $countones(vlds))
    else $error("live count disagrees with valid cells");

  a_full_implies_head: assert property (@(posedge clk) disable iff (rst)
    cells[CAPACITY-1].vld |-> cells[0].vld)
    else $error("tail cell valid while head empty");

  a_head_is_min: assert property (@(posedge clk) disable iff (rst)
    cells[1].vld |-> (cells[0].vld && (cells[0].val <= cells[1].val)))
    else $error("head cell not the smallest entry");

  a_overflow_holds: assert property (@(posedge clk) disable iff (rst)
    (accept && (action == sapq_pkg::ACT_INSERT) && full) |=> $stable(count))
    else $error("count changed on overflowing insert");

endmodule
